@@ sv/somc_pkg.sv @@
// Shared types, constants and the square-root step for the scaled orthogonal matrix check.
package somc_pkg;

  localparam int ENTRY_W   = 24;
  localparam int N_DIM     = 3;
  localparam int N_ENTRY   = N_DIM * N_DIM;
  localparam int IN_W      = N_ENTRY * ENTRY_W;
  localparam int PROD_W    = 2 * ENTRY_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int N_DOT     = 6;
  localparam int N_PROD    = N_DOT * N_DIM;
  localparam int MAG_W     = PROD_W;
  localparam int TOL_W     = 32;
  localparam int ROOT_W    = MAG_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int SQ_STAGES = ROOT_W;
  localparam int OUT_W     = 32;
  localparam int CFG_AW    = 3;

  localparam logic [TOL_W-1:0] TOL_RESET = 32'd42950;
  localparam logic             REG_TOL   = 1'b0;

  // Classified matrix handed from the front end to the square-root back end.
  typedef struct packed {
    logic             ok;
    logic [MAG_W-1:0] diag;
  } chk_t;

  // One stage of the bit-per-stage integer square root.
  typedef struct packed {
    logic              ok;
    logic [MAG_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  function automatic sq_t sqrt_step(input sq_t s);
    sq_t              r;
    logic [REM_W+1:0] cat;
    logic [REM_W+1:0] trial;
    r     = s;
    cat   = {s.rem, s.rad[MAG_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    r.rad = {s.rad[MAG_W-3:0], 2'b00};
    if (cat >= trial) begin
      r.rem  = REM_W'(cat - trial);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = REM_W'(cat);
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

@@ sv/somc_front.sv @@
// Front end: row dot products, deviations and the tolerance check, four pipeline stages.
module somc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [somc_pkg::IN_W-1:0]     in_data,
  input  logic [somc_pkg::TOL_W-1:0]    tolerance,
  output logic                          chk_valid,
  input  logic                          chk_ready,
  output somc_pkg::chk_t                chk
);

  localparam int DI [somc_pkg::N_DOT] = '{0, 1, 2, 0, 0, 1};
  localparam int DJ [somc_pkg::N_DOT] = '{0, 1, 2, 1, 2, 2};

  logic en;
  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [somc_pkg::PROD_W-1:0] prod_nxt [somc_pkg::N_PROD];
  logic signed [somc_pkg::PROD_W-1:0] prod_r   [somc_pkg::N_PROD];
  logic signed [somc_pkg::DOT_W-1:0]  dot_nxt  [somc_pkg::N_DOT];
  logic signed [somc_pkg::DOT_W-1:0]  dot_r    [somc_pkg::N_DOT];
  logic signed [somc_pkg::DOT_W-1:0]  diff     [somc_pkg::N_DOT];
  logic [somc_pkg::MAG_W-1:0]         dev_nxt  [somc_pkg::N_DOT];
  logic [somc_pkg::MAG_W-1:0]         dev_r    [somc_pkg::N_DOT];
  logic [somc_pkg::MAG_W-1:0]         diag3_r;
  logic                               ok_nxt;
  somc_pkg::chk_t                     chk_r;

  assign en        = !(v4_r && !chk_ready);
  assign in_ready  = en;
  assign chk_valid = v4_r;
  assign chk       = chk_r;

  always_comb begin
    for (int d = 0; d < somc_pkg::N_DOT; d++) begin
      for (int k = 0; k < somc_pkg::N_DIM; k++) begin
        prod_nxt[d*somc_pkg::N_DIM + k] =
          $signed(in_data[(DI[d]*somc_pkg::N_DIM + k)*somc_pkg::ENTRY_W +: somc_pkg::ENTRY_W]) *
          $signed(in_data[(DJ[d]*somc_pkg::N_DIM + k)*somc_pkg::ENTRY_W +: somc_pkg::ENTRY_W]);
      end
    end
  end

  always_comb begin
    for (int d = 0; d < somc_pkg::N_DOT; d++) begin
      dot_nxt[d] = somc_pkg::DOT_W'(prod_r[d*somc_pkg::N_DIM])
                 + somc_pkg::DOT_W'(prod_r[d*somc_pkg::N_DIM + 1])
                 + somc_pkg::DOT_W'(prod_r[d*somc_pkg::N_DIM + 2]);
    end
  end

  always_comb begin
    diff[0] = dot_r[0] - dot_r[1];
    diff[1] = dot_r[0] - dot_r[2];
    diff[2] = dot_r[1] - dot_r[2];
    diff[3] = dot_r[3];
    diff[4] = dot_r[4];
    diff[5] = dot_r[5];
    for (int d = 0; d < somc_pkg::N_DOT; d++) begin
      dev_nxt[d] = diff[d][somc_pkg::DOT_W-1] ? somc_pkg::MAG_W'(-diff[d])
                                               : somc_pkg::MAG_W'(diff[d]);
    end
  end

  always_comb begin
    ok_nxt = 1'b1;
    for (int d = 0; d < somc_pkg::N_DOT; d++) begin
      if (dev_r[d] > somc_pkg::MAG_W'(tolerance)) begin
        ok_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r     <= prod_nxt;
      dot_r      <= dot_nxt;
      dev_r      <= dev_nxt;
      diag3_r    <= somc_pkg::MAG_W'(dot_r[0]);
      chk_r.ok   <= ok_nxt;
      chk_r.diag <= diag3_r;
    end
  end

endmodule

@@ sv/somc_fifo.sv @@
// Two-entry queue between the front end and the square-root back end.
module somc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  somc_pkg::chk_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output somc_pkg::chk_t rd_data
);

  somc_pkg::chk_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

@@ sv/somc_sqrt.sv @@
// Back end: pipelined integer square root, one root bit per stage, last stage is the output register.
module somc_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          chk_valid,
  output logic                          chk_ready,
  input  somc_pkg::chk_t                chk,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          res_ok,
  output logic [somc_pkg::ROOT_W-1:0]   res_scale
);

  localparam int NS = somc_pkg::SQ_STAGES;

  logic          en;
  logic          vld_r [NS];
  somc_pkg::sq_t st_r  [NS];
  somc_pkg::sq_t head;

  assign en        = !vld_r[NS-1] || res_ready;
  assign chk_ready = en;
  assign res_valid = vld_r[NS-1];
  assign res_ok    = st_r[NS-1].ok;
  assign res_scale = st_r[NS-1].ok ? st_r[NS-1].root : '0;

  always_comb begin
    head.ok   = chk.ok;
    head.rad  = chk.diag;
    head.rem  = '0;
    head.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= chk_valid;
      for (int k = 1; k < NS; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= somc_pkg::sqrt_step(head);
      for (int k = 1; k < NS; k++) begin
        st_r[k] <= somc_pkg::sqrt_step(st_r[k-1]);
      end
    end
  end

endmodule

@@ sv/scaled_orthogonal_matrix_check_top.sv @@
// Path from input transaction to result: 4 front stages, the two-entry queue and 24 root stages.
// Throughput: one matrix per cycle while out_tready holds high, set by the fully pipelined multipliers and root stages.
// The two-entry queue lets the front end keep accepting while the back end holds a result.
// Reset (rst_n, synchronous, active low) empties all stages and the queue and sets
// tolerance to 42950.
module scaled_orthogonal_matrix_check_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // row0_col0, row0_col1, row0_col2, row1_col0, ..., row2_col2; 24 bits each
  input  logic [somc_pkg::IN_W-1:0]     in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // is_ortho_scalar [0], uniform_scale [24:1], zero fill [31:25]
  output logic [somc_pkg::OUT_W-1:0]    out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [somc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic [somc_pkg::TOL_W-1:0]  tol_r;
  logic                        f_valid, f_ready, q_valid, q_ready;
  somc_pkg::chk_t              f_chk, q_chk;
  logic                        res_ok;
  logic [somc_pkg::ROOT_W-1:0] res_scale;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == somc_pkg::REG_TOL) ? tol_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= somc_pkg::TOL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == somc_pkg::REG_TOL) begin
      tol_r <= cfg_pwdata;
    end
  end

  somc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .tolerance (tol_r),
    .chk_valid (f_valid),
    .chk_ready (f_ready),
    .chk       (f_chk)
  );

  somc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_chk),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_chk)
  );

  somc_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .chk_valid (q_valid),
    .chk_ready (q_ready),
    .chk       (q_chk),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_ok    (res_ok),
    .res_scale (res_scale)
  );

  assign out_tdata = {7'b0, res_scale, res_ok};

endmodule
